FILE: src/tswa_pkg.sv
// ----------------------------------------------------------------------------
// tswa_pkg
// Shared types, operation codes and the type cast for the typed wrapping ALU.
// ----------------------------------------------------------------------------
package tswa_pkg;

   localparam int WORD_WIDTH = 64;
   localparam int HALF_WIDTH = WORD_WIDTH / 2;
   localparam int DIV_STAGES = WORD_WIDTH;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [HALF_WIDTH-1:0] half_type;
   typedef logic [3:0]            op_type;
   typedef logic [2:0]            otype_type;
   typedef logic signed [6:0]     shamt_type;

   localparam op_type OP_SET = 4'd0;
   localparam op_type OP_ADD = 4'd1;
   localparam op_type OP_SUB = 4'd2;
   localparam op_type OP_MUL = 4'd3;
   localparam op_type OP_DIV = 4'd4;
   localparam op_type OP_NOT = 4'd5;
   localparam op_type OP_AND = 4'd6;
   localparam op_type OP_OR  = 4'd7;
   localparam op_type OP_XOR = 4'd8;
   localparam op_type OP_SHL = 4'd9;
   localparam op_type OP_SHR = 4'd10;

   localparam otype_type TYPE_I64 = 3'd6;
   localparam otype_type TYPE_U64 = 3'd7;

   // Cast to 8/16/32/64 bits, then sign or zero extend (bit 0 clear = signed).
   function automatic word_type to_type(word_type x, otype_type t);
      word_type m;
      logic     s;
      case (t[2:1])
         2'd0: begin m = word_type'(64'hFF);        s = x[7];  end
         2'd1: begin m = word_type'(64'hFFFF);      s = x[15]; end
         2'd2: begin m = word_type'(64'hFFFF_FFFF); s = x[31]; end
         default: begin m = '1;                     s = x[63]; end
      endcase
      if (!t[0] && s) begin
         to_type = x | ~m;
      end else begin
         to_type = x & m;
      end
   endfunction

endpackage

FILE: src/tswa_req_if.sv
// ----------------------------------------------------------------------------
// tswa_req_if
// Request channel: operation, operands and shift distance with valid/ready.
// ----------------------------------------------------------------------------
interface tswa_req_if import tswa_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    operation;
   word_type  left_value;
   word_type  right_operand;
   shamt_type shift_amount;

   modport source (output valid, operation, left_value, right_operand, shift_amount,
                   input ready);
   modport sink   (input valid, operation, left_value, right_operand, shift_amount,
                   output ready);
endinterface

FILE: src/tswa_rsp_if.sv
// ----------------------------------------------------------------------------
// tswa_rsp_if
// Response channel: raw result, typed result and divide error with valid/ready.
// ----------------------------------------------------------------------------
interface tswa_rsp_if import tswa_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type result_value;
   word_type typed_value;
   logic     divide_error;

   modport source (output valid, result_value, typed_value, divide_error, input ready);
   modport sink   (input valid, result_value, typed_value, divide_error, output ready);
endinterface

FILE: src/typed_width_wrapping_alu.sv
// ----------------------------------------------------------------------------
// typed_width_wrapping_alu
// Wrapping integer ALU for a configured 8/16/32/64-bit signed or unsigned type.
// ----------------------------------------------------------------------------
// Every operation passes through the same pipeline from request accept to response
// valid (input register, cast/partial products, multiply sum, 64 divider bit stages,
// output register). Throughput: one item per cycle; the whole pipe holds when
// the response is stalled. Reset (synchronous) clears all valid bits and sets
// the operand type to u64.
module typed_width_wrapping_alu import tswa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   tswa_req_if.sink       req_ch,
   tswa_rsp_if.source     rsp_ch,
   input  logic           csr_wr_en,
   input  otype_type      csr_wr_data
);

   typedef struct packed {
      op_type    op;
      word_type  a;
      word_type  b;
      shamt_type amt;
   } s0_type;

   typedef struct packed {
      op_type   op;
      word_type a;
      word_type r;
      word_type ta;
      word_type tb;
      word_type ll;
      half_type lh;
      half_type hl;
   } s1_type;

   typedef struct packed {
      op_type   op;
      word_type a;
      word_type r;
      word_type ub;
      logic     neg;
      logic     zero;
      word_type rem;
      word_type nq;
   } dv_type;

   otype_type otype_ff;
   logic      adv;
   logic      s0_v_ff, s1_v_ff;
   s0_type    s0_ff;
   s1_type    s1_ff, s1_in;
   logic      dv_v_ff [0:DIV_STAGES];
   dv_type    dv_ff   [0:DIV_STAGES];
   dv_type    dv0_in;
   logic      out_v_ff;
   word_type  res_ff, res_in, typ_ff;
   logic      err_ff, err_in;

   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         otype_ff <= TYPE_U64;
      end else if (csr_wr_en) begin
         otype_ff <= csr_wr_data;
      end
   end

   function automatic word_type shift_word(word_type x, shamt_type amt, logic left);
      logic [7:0] n;
      logic       dir;
      word_type   y;
      if (amt[6]) begin
         n   = 8'd128 - {1'b0, amt};
         dir = !left;
      end else begin
         n   = {1'b0, amt};
         dir = left;
      end
      if (n >= 8'(WORD_WIDTH)) begin
         y = '0;
      end else if (dir) begin
         y = x << n[5:0];
      end else begin
         y = x >> n[5:0];
      end
      shift_word = y;
   endfunction

   function automatic dv_type div_step(dv_type d);
      logic [WORD_WIDTH:0] r2;
      logic                ge;
      dv_type              o;
      o  = d;
      r2 = {d.rem, d.nq[WORD_WIDTH-1]};
      ge = r2 >= {1'b0, d.ub};
      o.rem = ge ? WORD_WIDTH'(r2 - {1'b0, d.ub}) : r2[WORD_WIDTH-1:0];
      o.nq  = {d.nq[WORD_WIDTH-2:0], ge};
      div_step = o;
   endfunction

   // stage 1: casts, simple results, 32x32 partial products
   always_comb begin
      s1_in.op = s0_ff.op;
      s1_in.a  = s0_ff.a;
      s1_in.ta = to_type(s0_ff.a, otype_ff);
      s1_in.tb = to_type(s0_ff.b, otype_ff);
      s1_in.ll = word_type'(s0_ff.a[HALF_WIDTH-1:0]) * word_type'(s0_ff.b[HALF_WIDTH-1:0]);
      s1_in.lh = half_type'(s0_ff.a[HALF_WIDTH-1:0] * s0_ff.b[WORD_WIDTH-1:HALF_WIDTH]);
      s1_in.hl = half_type'(s0_ff.a[WORD_WIDTH-1:HALF_WIDTH] * s0_ff.b[HALF_WIDTH-1:0]);
      case (s0_ff.op)
         OP_SET:  s1_in.r = to_type(s0_ff.b, otype_ff);
         OP_ADD:  s1_in.r = to_type(s0_ff.a + s0_ff.b, otype_ff);
         OP_SUB:  s1_in.r = to_type(s0_ff.a - s0_ff.b, otype_ff);
         OP_NOT:  s1_in.r = ~s0_ff.a;
         OP_AND:  s1_in.r = s0_ff.a & s0_ff.b;
         OP_OR:   s1_in.r = s0_ff.a | s0_ff.b;
         OP_XOR:  s1_in.r = s0_ff.a ^ s0_ff.b;
         OP_SHL:  s1_in.r = to_type(shift_word(s0_ff.a, s0_ff.amt, 1'b1), otype_ff);
         OP_SHR:  s1_in.r = to_type(shift_word(s0_ff.a, s0_ff.amt, 1'b0), otype_ff);
         default: s1_in.r = s0_ff.a;
      endcase
   end

   // stage 2: multiply sum, divider operand magnitudes
   always_comb begin
      logic sgn;
      sgn         = !otype_ff[0];
      dv0_in.op   = s1_ff.op;
      dv0_in.a    = s1_ff.a;
      dv0_in.r    = (s1_ff.op == OP_MUL)
                    ? to_type(s1_ff.ll + {s1_ff.lh + s1_ff.hl, half_type'(0)}, otype_ff)
                    : s1_ff.r;
      dv0_in.neg  = sgn && (s1_ff.ta[WORD_WIDTH-1] ^ s1_ff.tb[WORD_WIDTH-1]);
      dv0_in.zero = (s1_ff.tb == '0);
      dv0_in.nq   = (sgn && s1_ff.ta[WORD_WIDTH-1]) ? -s1_ff.ta : s1_ff.ta;
      dv0_in.ub   = (sgn && s1_ff.tb[WORD_WIDTH-1]) ? -s1_ff.tb : s1_ff.tb;
      dv0_in.rem  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff    <= 1'b0;
         s1_v_ff    <= 1'b0;
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         s0_v_ff    <= req_ch.valid;
         s1_v_ff    <= s0_v_ff;
         dv_v_ff[0] <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff.op  <= req_ch.operation;
         s0_ff.a   <= req_ch.left_value;
         s0_ff.b   <= req_ch.right_operand;
         s0_ff.amt <= req_ch.shift_amount;
         s1_ff     <= s1_in;
         dv_ff[0]  <= dv0_in;
      end
   end

   // divider: one quotient bit per stage
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[g+1] <= dv_v_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[g+1] <= div_step(dv_ff[g]);
         end
      end
   end

   always_comb begin
      dv_type d;
      d      = dv_ff[DIV_STAGES];
      err_in = 1'b0;
      res_in = d.r;
      if (d.op == OP_DIV) begin
         if (d.zero) begin
            err_in = 1'b1;
            res_in = d.a;
         end else begin
            res_in = to_type(d.neg ? -d.nq : d.nq, otype_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         typ_ff <= to_type(res_in, otype_ff);
         err_ff <= err_in;
      end
   end

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.result_value = res_ff;
   assign rsp_ch.typed_value  = typ_ff;
   assign rsp_ch.divide_error = err_ff;

endmodule

FILE: src/tswa_checker.sv
// ----------------------------------------------------------------------------
// tswa_checker
// Port-level checks for the typed wrapping ALU, bound to the top level.
// ----------------------------------------------------------------------------
module tswa_checker import tswa_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input word_type  rsp_result_value,
   input word_type  rsp_typed_value,
   input logic      rsp_divide_error,
   input logic      csr_wr_en,
   input otype_type csr_wr_data
);

   otype_type otype_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         otype_ff <= TYPE_U64;
      end else if (csr_wr_en) begin
         otype_ff <= csr_wr_data;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_divide_error))
      else $error("stalled response changed");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   a_u64_typed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && otype_ff == TYPE_U64 |-> rsp_typed_value == rsp_result_value)
      else $error("u64 typed value differs from raw value");

endmodule

bind typed_width_wrapping_alu tswa_checker u_tswa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_typed_value  (rsp_ch.typed_value),
   .rsp_divide_error (rsp_ch.divide_error),
   .csr_wr_en        (csr_wr_en),
   .csr_wr_data      (csr_wr_data)
);

FILE: sim/typed_width_wrapping_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_width_wrapping_alu_tb
// Checks the typed wrapping ALU. Items are predicted with a local cast and
// divide model and compared in order, under random idling on both channels
// and across every operand type.
// ----------------------------------------------------------------------------
module typed_width_wrapping_alu_tb;
   import tswa_pkg::*;

   typedef struct {
      op_type    op;
      word_type  lhs;
      word_type  rhs;
      shamt_type amt;
   } alu_item_type;

   typedef struct {
      word_type raw;
      word_type typed;
      logic     dz;
   } alu_result_type;

   localparam int PIPE_DEPTH = 68;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   otype_type csr_wr_data = TYPE_U64;

   tswa_req_if req_ch ();
   tswa_rsp_if rsp_ch ();

   typed_width_wrapping_alu dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   alu_item_type   pending_items[$];
   alu_result_type expected_results[$];
   otype_type      cur_type = TYPE_U64;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   bit             hold_sender = 1'b0;
   int             mismatches = 0;
   bit             accepted_flag = 1'b0;

   function automatic int type_width(otype_type t);
      return 8 << t[2:1];
   endfunction

   function automatic word_type cast_word(word_type x, otype_type t);
      int w;
      word_type m;
      w = type_width(t);
      m = (w == 64) ? '1 : ((word_type'(1) << w) - 1);
      x = x & m;
      if (!t[0] && x[w-1]) x = x | ~m;
      return x;
   endfunction

   function automatic word_type typed_quotient(word_type a, word_type b, otype_type t);
      word_type ua, ub, q;
      bit neg;
      a = cast_word(a, t);
      b = cast_word(b, t);
      if (t[0]) return cast_word(a / b, t);
      neg = 1'b0;
      ua = a;
      ub = b;
      if (a[63]) begin ua = -a; neg = !neg; end
      if (b[63]) begin ub = -b; neg = !neg; end
      q = ua / ub;
      if (neg) q = -q;
      return cast_word(q, t);
   endfunction

   function automatic word_type shifted_word(word_type x, shamt_type amt, bit left,
                                             otype_type t);
      int n;
      word_type r;
      n = amt;
      if (n < 0) begin
         n = -n;
         left = !left;
      end
      if (n >= 64) r = '0;
      else r = left ? (x << n) : (x >> n);
      return cast_word(r, t);
   endfunction

   function automatic alu_result_type alu_predict(alu_item_type it, otype_type t);
      alu_result_type r;
      r.raw = it.lhs;
      r.dz = 1'b0;
      case (it.op)
         OP_SET: r.raw = cast_word(it.rhs, t);
         OP_ADD: r.raw = cast_word(it.lhs + it.rhs, t);
         OP_SUB: r.raw = cast_word(it.lhs - it.rhs, t);
         OP_MUL: r.raw = cast_word(it.lhs * it.rhs, t);
         OP_DIV: begin
            if (cast_word(it.rhs, t) == '0) r.dz = 1'b1;
            else r.raw = typed_quotient(it.lhs, it.rhs, t);
         end
         OP_NOT: r.raw = ~it.lhs;
         OP_AND: r.raw = it.lhs & it.rhs;
         OP_OR:  r.raw = it.lhs | it.rhs;
         OP_XOR: r.raw = it.lhs ^ it.rhs;
         OP_SHL: r.raw = shifted_word(it.lhs, it.amt, 1'b1, t);
         OP_SHR: r.raw = shifted_word(it.lhs, it.amt, 1'b0, t);
         default: r.raw = it.lhs;
      endcase
      r.typed = cast_word(r.raw, t);
      return r;
   endfunction

   // ready can fall right after the edge, so the handshake is captured at posedge
   always @(posedge clock) accepted_flag <= req_ch.valid && req_ch.ready && !reset;

   // driver: prediction made at acceptance so the queue order matches the pipe
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (accepted_flag) begin
            alu_item_type done;
            done.op = req_ch.operation;
            done.lhs = req_ch.left_value;
            done.rhs = req_ch.right_operand;
            done.amt = req_ch.shift_amount;
            expected_results.push_back(alu_predict(done, cur_type));
            void'(pending_items.pop_front());
         end
         if (pending_items.size() > 0 && !hold_sender && !csr_wr_en
             && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.operation <= pending_items[0].op;
            req_ch.left_value <= pending_items[0].lhs;
            req_ch.right_operand <= pending_items[0].rhs;
            req_ch.shift_amount <= pending_items[0].amt;
         end else begin
            req_ch.valid <= 1'b0;
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result raw=%h", rsp_ch.result_value);
         end else begin
            alu_result_type e;
            e = expected_results.pop_front();
            if (e.raw !== rsp_ch.result_value || e.typed !== rsp_ch.typed_value
                || e.dz !== rsp_ch.divide_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp raw=%h typed=%h dz=%b got raw=%h typed=%h dz=%b",
                           e.raw, e.typed, e.dz, rsp_ch.result_value,
                           rsp_ch.typed_value, rsp_ch.divide_error);
            end
         end
      end
   end

   function automatic word_type rand_word();
      word_type w;
      w = {$urandom, $urandom};
      case ($urandom_range(7))
         0: w = '0;
         1: w = '1;
         2: w = 64'h8000_0000_0000_0000;
         3: w = word_type'($urandom_range(255));
         4: w = {{56{w[7]}}, w[7:0]};
         5: w = {{32{w[31]}}, w[31:0]};
         default: ;
      endcase
      return w;
   endfunction

   task automatic queue_item(op_type op, word_type a, word_type b, shamt_type s);
      alu_item_type it;
      it.op = op;
      it.lhs = a;
      it.rhs = b;
      it.amt = s;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      wait (pending_items.size() == 0 && expected_results.size() == 0);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_type(otype_type t);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= t;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_type = t;
   endtask

   task automatic queue_directed();
      for (int op = 0; op < 16; op++)
         queue_item(op_type'(op), 64'h8000_0000_0000_0080, 64'hFFFF_FFFF_FFFF_FFFF, -7'sd3);
      queue_item(OP_DIV, 64'h1234, 64'h0, 7'sd0);
      queue_item(OP_DIV, 64'h8000_0000_0000_0000, '1, 7'sd0);
      queue_item(OP_DIV, 64'h80, 64'hFF, 7'sd0);
      queue_item(OP_DIV, 64'h8000_0000, 64'hFFFF_FFFF, 7'sd0);
      queue_item(OP_SHL, '1, '0, shamt_type'(-64));
      queue_item(OP_SHR, '1, '0, 7'sd63);
      queue_item(OP_ADD, '1, 64'h1, 7'sd0);
      queue_item(OP_MUL, '1, '1, 7'sd0);
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++)
         queue_item(op_type'($urandom_range(11)), rand_word(), rand_word(),
                    shamt_type'($urandom_range(127)));
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = OP_SET;
      req_ch.left_value = '0;
      req_ch.right_operand = '0;
      req_ch.shift_amount = '0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      queue_directed();
      drain();
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 30 : (p == 1) ? 62 : 0;
         recv_idle_pct = (p == 0) ? 62 : (p == 1) ? 30 : 0;
         for (int t = 0; t < 8; t++) begin
            write_type(otype_type'((t + p * 3) % 8));
            if (t == 0) queue_directed();
            queue_random(60);
            if (t == 4) begin
               // let part of the batch in, then stop until all results are back
               wait (pending_items.size() < 30);
               @(negedge clock);
               hold_sender = 1'b1;
               repeat (2) @(negedge clock);
               wait (expected_results.size() == 0);
               @(negedge clock);
               hold_sender = 1'b0;
            end
            drain();
         end
      end
      write_type(TYPE_I64);
      queue_random(40);
      drain();
      write_type(TYPE_U64);
      queue_random(40);
      drain();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("typed_width_wrapping_alu regression: pass");
      end else begin
         $display("typed_width_wrapping_alu regression: fail");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("typed_width_wrapping_alu regression: fail");
      $finish;
   end
endmodule

FILE: sim.f
src/tswa_pkg.sv
src/tswa_req_if.sv
src/tswa_rsp_if.sv
src/typed_width_wrapping_alu.sv
src/tswa_checker.sv
sim/typed_width_wrapping_alu_tb.sv
